FILE: sv/sdinit_pkg.sv
// Package for the SD card bring-up sequencer: payload types, phase codes and command tables.
`default_nettype none
package sdinit_pkg;

	// Payload of one input transaction.
	typedef struct packed {
		logic        operation;
		logic [31:0] response;
	} sdinit_in_t;

	// Payload of one result transaction.
	typedef struct packed {
		logic        issue;
		logic [5:0]  cmd_index;
		logic [31:0] cmd_arg;
		logic [31:0] cmd_word;
		logic [1:0]  outcome;
		logic [15:0] card_addr;
		logic [3:0]  card_state;
	} sdinit_out_t;

	// Sequencer phases; the codes above PH_FAIL are treated as idle.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_CMD0   = 4'd1,
		PH_CMD8   = 4'd2,
		PH_CMD55  = 4'd3,
		PH_ACMD41 = 4'd4,
		PH_CMD2   = 4'd5,
		PH_CMD3   = 4'd6,
		PH_CMD7   = 4'd7,
		PH_CMD13  = 4'd8,
		PH_DONE   = 4'd9,
		PH_FAIL   = 4'd10
	} sdinit_phase_t;

	// Operation codes of an input transaction.
	localparam logic OP_START    = 1'b0;
	localparam logic OP_COMPLETE = 1'b1;

	// Outcome codes.
	localparam logic [1:0] OUTCOME_BUSY     = 2'd0;
	localparam logic [1:0] OUTCOME_SUCCESS  = 2'd1;
	localparam logic [1:0] OUTCOME_MISMATCH = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PATTERN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_WINDOW = 1'd1;

	localparam logic [7:0]  CHECK_PATTERN_RESET  = 8'h13;
	localparam logic [23:0] VOLTAGE_WINDOW_RESET = 24'h30_0000;

	// Command indexes used by the sequence.
	localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
	localparam logic [5:0] CMD_ALL_SEND_ID = 6'd2;
	localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
	localparam logic [5:0] CMD_SELECT      = 6'd7;
	localparam logic [5:0] CMD_IF_COND     = 6'd8;
	localparam logic [5:0] CMD_STATUS      = 6'd13;
	localparam logic [5:0] ACMD_OP_COND    = 6'd41;
	localparam logic [5:0] CMD_APP         = 6'd55;

	// Response-type bits of the command word.
	localparam logic [15:0] RT_NONE   = 16'h0000;
	localparam logic [15:0] RT_R1     = 16'hA000;
	localparam logic [15:0] RT_R1B    = 16'hB000;
	localparam logic [15:0] RT_R2     = 16'h9000;
	localparam logic [15:0] RT_48_RAW = 16'h2000;

	localparam logic [7:0] IF_COND_VHS = 8'h01;

	// Response-type bits for each command index.
	localparam logic [15:0] RESP_BITS [64] = '{
		RT_NONE, RT_NONE, RT_R2,   RT_R1,   RT_NONE, RT_NONE, RT_R1,   RT_R1B,
		RT_R1,   RT_R2,   RT_R2,   RT_R1,   RT_R1B,  RT_R1,   RT_NONE, RT_NONE,
		RT_R1,   RT_R1,   RT_R1,   RT_R1,   RT_R1B,  RT_NONE, RT_NONE, RT_R1,
		RT_R1,   RT_R1,   RT_NONE, RT_R1,   RT_R1B,  RT_R1B,  RT_R1,   RT_NONE,
		RT_R1,   RT_R1,   RT_NONE, RT_NONE, RT_NONE, RT_NONE, RT_R1B,  RT_NONE,
		RT_NONE, RT_NONE, RT_R1,   RT_R1,   RT_NONE, RT_NONE, RT_NONE, RT_NONE,
		RT_R1,   RT_R1,   RT_NONE, RT_NONE, RT_NONE, RT_NONE, RT_NONE, RT_R1,
		RT_R1,   RT_NONE, RT_R1,   RT_R1,   RT_NONE, RT_NONE, RT_NONE, RT_NONE
	};

endpackage
`default_nettype wire

FILE: sv/sd_card_init_sequencer_core.sv
// SD card bring-up sequencer: input register, phase logic and a two-entry result queue.
// A result is computed from the input register and moves into the result queue, from which
// it is offered; an item waits in the input register while the skid entry is full.
// Throughput: one transaction per cycle while the skid entry is free; the phase and address
// update in the cycle an item leaves the input register, so the next item already sees them.
// Reset (arst_n low, asynchronous) returns the phase to idle, clears the card address,
// loads the default check pattern and voltage window and empties the input register and queue.
`default_nettype none
module sd_card_init_sequencer_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire sdinit_pkg::sdinit_in_t         in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output sdinit_pkg::sdinit_out_t             out_data,
	input  wire logic                           cfg_write_en,
	input  wire logic [sdinit_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [23:0]                    cfg_data
);
	import sdinit_pkg::*;

	// Configuration registers.
	logic [7:0]  check_pattern_q;
	logic [23:0] voltage_window_q;

	// Sequencer state.
	sdinit_phase_t phase_q, phase_d;
	logic [15:0]   rel_addr_q, rel_addr_d;

	// Input register.
	logic       valid_s1;
	sdinit_in_t data_s1;

	// Result queue: a main output register plus a skid entry, so a new item can
	// move on while a finished result still waits on the output side.
	logic        main_valid_q, skid_valid_q;
	sdinit_out_t main_q, skid_q;
	sdinit_out_t result;

	logic push, pop;

	assign push     = valid_s1 && !skid_valid_q;
	assign pop      = main_valid_q && out_ready;
	assign in_ready = !valid_s1 || push;

	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// Register writes only while the block is idle: the user is bound to this, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_pattern_q  <= CHECK_PATTERN_RESET;
			voltage_window_q <= VOLTAGE_WINDOW_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_CHECK_PATTERN:  check_pattern_q  <= cfg_data[7:0];
				CFG_VOLTAGE_WINDOW: voltage_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// Next phase and captured address for the item in the input register.
	always_comb begin
		phase_d    = phase_q;
		rel_addr_d = rel_addr_q;
		if (data_s1.operation == OP_START) begin
			phase_d    = PH_CMD0;
			rel_addr_d = '0;
		end else begin
			unique case (phase_q)
				PH_CMD0:   phase_d = PH_CMD8;
				PH_CMD8: begin
					if (data_s1.response[7:0] != check_pattern_q) begin
						phase_d = PH_FAIL;
					end else begin
						phase_d = PH_CMD55;
					end
				end
				PH_CMD55:  phase_d = PH_ACMD41;
				PH_ACMD41: begin
					// The card reports power-up done in bit 31; until then keep retrying.
					if (data_s1.response[31]) begin
						phase_d = PH_CMD2;
					end else begin
						phase_d = PH_CMD55;
					end
				end
				PH_CMD2:   phase_d = PH_CMD3;
				PH_CMD3: begin
					phase_d    = PH_CMD7;
					rel_addr_d = data_s1.response[31:16];
				end
				PH_CMD7:   phase_d = PH_CMD13;
				PH_CMD13:  phase_d = PH_DONE;
				default:   phase_d = phase_q;
			endcase
		end
	end

	// Result fields for the item in the input register.
	always_comb begin
		logic [15:0] rtype;
		rtype             = RT_NONE;
		result            = '0;
		if (data_s1.operation == OP_START) begin
			result.issue     = 1'b1;
			result.cmd_index = CMD_GO_IDLE;
		end else begin
			unique case (phase_q)
				PH_CMD0: begin
					result.issue     = 1'b1;
					result.cmd_index = CMD_IF_COND;
					result.cmd_arg   = {16'h0000, IF_COND_VHS, check_pattern_q};
				end
				PH_CMD8: begin
					if (data_s1.response[7:0] == check_pattern_q) begin
						result.issue     = 1'b1;
						result.cmd_index = CMD_APP;
					end
				end
				PH_CMD55: begin
					result.issue     = 1'b1;
					result.cmd_index = ACMD_OP_COND;
					result.cmd_arg   = {8'h00, voltage_window_q};
				end
				PH_ACMD41: begin
					result.issue     = 1'b1;
					result.cmd_index = data_s1.response[31] ? CMD_ALL_SEND_ID : CMD_APP;
				end
				PH_CMD2: begin
					result.issue     = 1'b1;
					result.cmd_index = CMD_SEND_RCA;
				end
				PH_CMD3: begin
					result.issue     = 1'b1;
					result.cmd_index = CMD_SELECT;
					result.cmd_arg   = {data_s1.response[31:16], 16'h0000};
				end
				PH_CMD7: begin
					result.issue     = 1'b1;
					result.cmd_index = CMD_STATUS;
					result.cmd_arg   = {rel_addr_q, 16'h0000};
				end
				PH_CMD13: begin
					result.card_state = data_s1.response[12:9];
				end
				default: ;
			endcase
		end
		// The operating condition command answers without a CRC check.
		if (result.issue && result.cmd_index == ACMD_OP_COND) begin
			rtype = RT_48_RAW;
		end else if (result.issue) begin
			rtype = RESP_BITS[result.cmd_index];
		end
		result.cmd_word  = {2'b00, result.cmd_index, 8'h00, rtype};
		result.card_addr = rel_addr_d;
		if (phase_d == PH_DONE) begin
			result.outcome = OUTCOME_SUCCESS;
		end else if (phase_d == PH_FAIL) begin
			result.outcome = OUTCOME_MISMATCH;
		end else begin
			result.outcome = OUTCOME_BUSY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			rel_addr_q <= '0;
		end else if (push) begin
			phase_q    <= phase_d;
			rel_addr_q <= rel_addr_d;
		end
	end

	// Queue control. A push never coincides with a full skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!push) begin
				main_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_valid_q) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= result;
			end
		end else if (push) begin
			if (!main_valid_q) begin
				main_q <= result;
			end else begin
				skid_q <= result;
			end
		end
	end

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the SD card bring-up sequencer: directed vectors, then random bring-ups.
`timescale 1ns / 1ps
module tb_top;
	import sdinit_pkg::*;

	// Generous ceiling for at least 470 transactions, the slowest stall profile included.
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned RANDOM_PER_PHASE = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sdinit_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sdinit_out_t out_data;
	logic cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CHECK_PATTERN;
	logic [23:0] cfg_data = '0;

	always #4 clk = ~clk;

	sd_card_init_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the sequencer: where it is in the bring-up, the captured card address,
	// and the two configuration registers as last written.
	sdinit_phase_t bringup_phase = PH_IDLE;
	logic [15:0] bringup_rca = 16'h0000;
	logic [7:0] cur_pattern = CHECK_PATTERN_RESET;
	logic [23:0] cur_window = VOLTAGE_WINDOW_RESET;

	// Commands the sequencer still owes us, oldest first.
	sdinit_out_t awaited_commands[$];

	int unsigned send_gap_pct = 0;
	int unsigned recv_gap_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned fail_count = 0;
	int unsigned sent_count = 0;
	int unsigned results_checked = 0;
	int unsigned bringups_done = 0;
	int unsigned pattern_failures = 0;
	int unsigned opcond_retries = 0;

	// One row of the directed table. When typed is set, want holds the result read straight
	// off the spec; otherwise the shadow model supplies it.
	typedef struct {
		logic typed;
		sdinit_in_t stim;
		sdinit_out_t want;
	} bringup_row_t;

	bringup_row_t directed_rows [21] = '{
		// A completion with nothing started must issue nothing.
		'{1'b1, {OP_COMPLETE, 32'hFFFF_FFFF}, {1'b0, 6'd0, 32'd0, 32'd0, OUTCOME_BUSY, 16'h0, 4'h0}},
		'{1'b1, {OP_START, 32'h0000_0000}, {1'b1, CMD_GO_IDLE, 32'd0, 32'd0, OUTCOME_BUSY, 16'h0, 4'h0}},
		'{1'b0, {OP_COMPLETE, 32'h0000_0000}, '0},
		// Interface condition echo with the wrong pattern ends in failure, and stays there.
		'{1'b1, {OP_COMPLETE, 32'h0000_01AA}, {1'b0, 6'd0, 32'd0, 32'd0, OUTCOME_MISMATCH, 16'h0, 4'h0}},
		'{1'b1, {OP_COMPLETE, 32'hFFFF_FFFF}, {1'b0, 6'd0, 32'd0, 32'd0, OUTCOME_MISMATCH, 16'h0, 4'h0}},
		// A start after failure recovers.
		'{1'b1, {OP_START, 32'hFFFF_FFFF}, {1'b1, CMD_GO_IDLE, 32'd0, 32'd0, OUTCOME_BUSY, 16'h0, 4'h0}},
		'{1'b0, {OP_COMPLETE, 32'h1234_5678}, '0},
		'{1'b0, {OP_COMPLETE, 32'hFFFF_FF13}, '0},
		'{1'b0, {OP_COMPLETE, 32'h0000_0000}, '0},
		// Card still busy: the application command goes out again.
		'{1'b0, {OP_COMPLETE, 32'h7FFF_FFFF}, '0},
		'{1'b0, {OP_COMPLETE, 32'hFFFF_FFFF}, '0},
		'{1'b0, {OP_COMPLETE, 32'h8000_0000}, '0},
		'{1'b0, {OP_COMPLETE, 32'h0000_0000}, '0},
		'{1'b0, {OP_COMPLETE, 32'hFFFF_0000}, '0},
		'{1'b0, {OP_COMPLETE, 32'h0000_FFFF}, '0},
		// Status response with every bit set: full address, card state all ones.
		'{1'b1, {OP_COMPLETE, 32'hFFFF_FFFF}, {1'b0, 6'd0, 32'd0, 32'd0, OUTCOME_SUCCESS, 16'hFFFF, 4'hF}},
		'{1'b1, {OP_COMPLETE, 32'h0000_0000}, {1'b0, 6'd0, 32'd0, 32'd0, OUTCOME_SUCCESS, 16'hFFFF, 4'h0}},
		// A start after success clears the captured address.
		'{1'b1, {OP_START, 32'h0000_0000}, {1'b1, CMD_GO_IDLE, 32'd0, 32'd0, OUTCOME_BUSY, 16'h0, 4'h0}},
		'{1'b0, {OP_COMPLETE, 32'hFFFF_FFFF}, '0},
		'{1'b0, {OP_COMPLETE, 32'h0000_0013}, '0},
		// Restart in the middle of the sequence.
		'{1'b1, {OP_START, 32'h0000_0000}, {1'b1, CMD_GO_IDLE, 32'd0, 32'd0, OUTCOME_BUSY, 16'h0, 4'h0}}
	};

	// Response-type bits for the commands this sequence sends.
	function automatic logic [15:0] resp_type_of(input logic [5:0] idx);
		case (idx)
			CMD_IF_COND, CMD_APP, CMD_SEND_RCA, CMD_STATUS: return RT_R1;
			CMD_ALL_SEND_ID: return RT_R2;
			CMD_SELECT: return RT_R1B;
			ACMD_OP_COND: return RT_48_RAW;
			default: return RT_NONE;
		endcase
	endfunction

	function automatic sdinit_out_t command(input logic [5:0] idx, input logic [31:0] arg);
		sdinit_out_t c;
		c = '0;
		c.issue = 1'b1;
		c.cmd_index = idx;
		c.cmd_arg = arg;
		c.cmd_word = {2'b00, idx, 8'h00, resp_type_of(idx)};
		return c;
	endfunction

	// Moves the shadow sequencer one transaction forward and returns the command it must emit.
	function automatic sdinit_out_t advance_bringup(input sdinit_in_t item);
		sdinit_out_t c;
		logic [3:0] state_field;
		c = '0;
		state_field = 4'h0;
		if (item.operation == OP_START) begin
			bringup_rca = 16'h0000;
			bringup_phase = PH_CMD0;
			c = command(CMD_GO_IDLE, 32'd0);
		end else begin
			case (bringup_phase)
				PH_CMD0: begin
					bringup_phase = PH_CMD8;
					c = command(CMD_IF_COND, {16'h0000, IF_COND_VHS, cur_pattern});
				end
				PH_CMD8: begin
					if (item.response[7:0] != cur_pattern) begin
						bringup_phase = PH_FAIL;
						pattern_failures++;
					end else begin
						bringup_phase = PH_CMD55;
						c = command(CMD_APP, 32'd0);
					end
				end
				PH_CMD55: begin
					bringup_phase = PH_ACMD41;
					c = command(ACMD_OP_COND, {8'h00, cur_window});
				end
				PH_ACMD41: begin
					// Bit 31 is the power-up done flag; until it is set the loop goes on.
					if (item.response[31]) begin
						bringup_phase = PH_CMD2;
						c = command(CMD_ALL_SEND_ID, 32'd0);
					end else begin
						bringup_phase = PH_CMD55;
						c = command(CMD_APP, 32'd0);
						opcond_retries++;
					end
				end
				PH_CMD2: begin
					bringup_phase = PH_CMD3;
					c = command(CMD_SEND_RCA, 32'd0);
				end
				PH_CMD3: begin
					bringup_rca = item.response[31:16];
					bringup_phase = PH_CMD7;
					c = command(CMD_SELECT, {bringup_rca, 16'h0000});
				end
				PH_CMD7: begin
					bringup_phase = PH_CMD13;
					c = command(CMD_STATUS, {bringup_rca, 16'h0000});
				end
				PH_CMD13: begin
					state_field = item.response[12:9];
					bringup_phase = PH_DONE;
					bringups_done++;
				end
				default: begin
				end
			endcase
		end
		if (bringup_phase == PH_DONE)
			c.outcome = OUTCOME_SUCCESS;
		else if (bringup_phase == PH_FAIL)
			c.outcome = OUTCOME_MISMATCH;
		else
			c.outcome = OUTCOME_BUSY;
		c.card_addr = bringup_rca;
		c.card_state = state_field;
		return c;
	endfunction

	task automatic report_problem(input string what);
		fail_count++;
		$display("%0t: %s", $time, what);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			report_problem($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
	endtask

	task automatic check_result(input sdinit_out_t got);
		sdinit_out_t want;
		if (awaited_commands.size() == 0) begin
			report_problem($sformatf("result 0x%0h arrived with nothing outstanding", got));
			return;
		end
		want = awaited_commands.pop_front();
		results_checked++;
		compare_field("issue", 32'(want.issue), 32'(got.issue));
		compare_field("cmd_index", 32'(want.cmd_index), 32'(got.cmd_index));
		compare_field("cmd_arg", want.cmd_arg, got.cmd_arg);
		compare_field("cmd_word", want.cmd_word, got.cmd_word);
		compare_field("outcome", 32'(want.outcome), 32'(got.outcome));
		compare_field("card_addr", 32'(want.card_addr), 32'(got.card_addr));
		compare_field("card_state", 32'(want.card_state), 32'(got.card_state));
	endtask

	// Result side: every accepted result is checked at the edge that takes it, and ready is
	// redrawn each cycle so that stalls land on any phase of the block's work.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_result(out_data);
		out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				awaited_commands.size());
			$display("status: fail");
			$finish;
		end
	end

	// Offers one transaction, holding valid and payload until it is taken. Valid is only
	// lowered when a gap is drawn, so it never drops and rises within one edge.
	task automatic send_request(input sdinit_in_t item, input logic typed,
			input sdinit_out_t want);
		sdinit_out_t predicted;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// Accepted at this edge: the shadow model always advances, the typed value wins.
		predicted = advance_bringup(item);
		awaited_commands.push_back(typed ? want : predicted);
		sent_count++;
	endtask

	// Waits until the block has handed back everything, plus a margin for its two-stage pipe.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_commands.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers on consecutive edges; only called with the block drained.
	task automatic program_regs(input logic [23:0] pattern_word, input logic [23:0] window_word);
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_CHECK_PATTERN;
		cfg_data <= pattern_word;
		@(posedge clk);
		cur_pattern = pattern_word[7:0];
		cfg_index <= CFG_VOLTAGE_WINDOW;
		cfg_data <= window_word;
		@(posedge clk);
		cur_window = window_word;
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	// Response words lean toward all zeros and all ones so both show up in every field.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Builds one bring-up attempt. Most are well formed with random response content; some
	// fail the pattern echo, some carry stray completions, and some are abandoned midway
	// so that the next start lands in the middle of a sequence.
	task automatic build_bringup(ref sdinit_in_t seq[$]);
		logic [31:0] w;
		int unsigned cut;
		seq.delete();
		if ($urandom_range(0, 9) == 0)
			seq.push_back({OP_COMPLETE, pick_word()});
		seq.push_back({OP_START, pick_word()});
		seq.push_back({OP_COMPLETE, pick_word()});
		w = pick_word();
		if ($urandom_range(0, 9) == 0) begin
			w[7:0] = cur_pattern ^ 8'($urandom_range(1, 255));
			seq.push_back({OP_COMPLETE, w});
			seq.push_back({OP_COMPLETE, pick_word()});
			return;
		end
		w[7:0] = cur_pattern;
		seq.push_back({OP_COMPLETE, w});
		repeat ($urandom_range(0, 3)) begin
			seq.push_back({OP_COMPLETE, pick_word()});
			w = pick_word();
			w[31] = 1'b0;
			seq.push_back({OP_COMPLETE, w});
		end
		seq.push_back({OP_COMPLETE, pick_word()});
		w = pick_word();
		w[31] = 1'b1;
		seq.push_back({OP_COMPLETE, w});
		// Identification, address, select and status responses.
		repeat (4) seq.push_back({OP_COMPLETE, pick_word()});
		if ($urandom_range(0, 3) == 0)
			seq.push_back({OP_COMPLETE, pick_word()});
		if ($urandom_range(0, 7) == 0) begin
			cut = $urandom_range(1, seq.size() - 1);
			seq = seq[0:cut-1];
		end
	endtask

	task automatic run_random(input int unsigned count);
		sdinit_in_t seq[$];
		int unsigned issued;
		issued = 0;
		while (issued < count) begin
			build_bringup(seq);
			foreach (seq[i])
				send_request(seq[i], 1'b0, '0);
			issued += seq.size();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender mostly busy, receiver mostly stalling; registers still at their reset values.
		send_gap_pct = 21;
		recv_gap_pct = 81;
		foreach (directed_rows[i])
			send_request(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
		drain_results();

		// Lowest pattern with junk above it, widest voltage window.
		program_regs({16'($urandom), 8'h00}, 24'hFF_FFFF);
		run_random(RANDOM_PER_PHASE);
		drain_results();

		// Now the sender idles and the receiver rarely stalls; highest pattern, empty window.
		send_gap_pct = 81;
		recv_gap_pct = 21;
		program_regs({16'($urandom), 8'hFF}, 24'h00_0000);
		run_random(RANDOM_PER_PHASE);
		drain_results();

		// Full rate on both sides with arbitrary register contents.
		send_gap_pct = 0;
		recv_gap_pct = 0;
		program_regs(24'($urandom), 24'($urandom));
		run_random(RANDOM_PER_PHASE);
		drain_results();
		repeat (8) @(posedge clk);

		$display("Sent %0d transactions and checked %0d results across three stall profiles.",
			sent_count, results_checked);
		$display("Bring-ups finished: %0d, pattern echo failures: %0d, busy retries: %0d.",
			bringups_done, pattern_failures, opcond_retries);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
sv/sdinit_pkg.sv
sv/sd_card_init_sequencer_core.sv
bench/tb_top.sv
